// ===== design/text_console_cursor_scroll_core_assert.svh =====
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCS_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tccs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCCS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tccs: next-cycle check failed");

`endif

// ===== design/tccs_pkg.sv =====
// Shared constants, types and address helper for the text console.
`default_nettype none

package tccs_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_END   = (ROWS - 1) * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT + 1);

  // Character codes with special meaning.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  // Attribute and cell contents after reset.
  localparam logic [7:0]  RESET_ATTR = 8'h0F;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

  // Command codes.
  typedef enum logic [2:0] {
    CMD_PUT_CHAR   = 3'd0,
    CMD_ERASE_BACK = 3'd1,
    CMD_PUT_AT     = 3'd2,
    CMD_SET_CURSOR = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_READ_CELL  = 3'd5
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== design/tccs_if.sv =====
// Valid/ready channel interfaces for console commands and results.
`default_nettype none

interface tccs_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [7:0] col_in;
  logic [7:0] row_in;

  modport source (output valid, cmd, char_code, col_in, row_in, input ready);
  modport sink   (input valid, cmd, char_code, col_in, row_in, output ready);
endinterface

interface tccs_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_linear;
  logic [15:0] cell_value;

  modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_value,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_value,
                  output ready);
endinterface

`default_nettype wire

// ===== design/text_console_cursor_scroll_core.sv =====
// Text console core: screen memory, cursor and command sequencer.
//
// Usage. Commands arrive on cmd_ch (valid/ready); one transfer carries cmd,
// char_code, col_in and row_in. Every command yields exactly one result
// transfer on res_ch with the cursor column, row, linear position and, for
// a cell read, the cell contents. The user writes the attribute register
// through cfg_we/cfg_wdata only while the core is idle; this is not enforced.
// Sequence: a command taken on cmd_ch passes through the execute state and then
// the done state, where the result register is loaded once it is free. A read
// of a cell on the screen adds a read-wait state between the two; a command
// that scrolls, and clear, add a sweep state. The screen sits in a single memory
// with one write port, so a sweep goes one cell per cycle. A new command is
// taken once the previous one has finished.
// Reset: synchronous, active high. After reset the core writes blank cells in
// attribute 0x0F over the whole screen and takes no command while it does so;
// attribute writes are accepted throughout.
// Stalls: the result sits in an output register. A stalled receiver does not
// stop the next command being taken; only its completion waits until the
// output register is free.
`default_nettype none

module text_console_cursor_scroll_core (
  input  wire logic       clk,
  input  wire logic       rst,
  tccs_cmd_if.sink        cmd_ch,
  tccs_res_if.source      res_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  // Screen memory and its registered read port.
  logic [15:0] mem [tccs_pkg::CELL_COUNT];
  logic [15:0] mem_rdata;
  logic        mem_we;
  logic [tccs_pkg::ADDR_W-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic        mem_re;
  logic [tccs_pkg::ADDR_W-1:0] mem_raddr;

  // Control and cursor.
  tccs_pkg::state_t state, state_next;
  logic [tccs_pkg::COL_W-1:0] cur_col, col_next;
  logic [tccs_pkg::ROW_W-1:0] cur_row, row_next;
  logic [7:0] attr;

  // Captured command.
  tccs_pkg::cmd_t cmd_q;
  logic [7:0] char_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic [15:0] cell_q;

  // Sweep engine for scroll, clear and the reset fill.
  logic [tccs_pkg::ADDR_W-1:0] sw_ptr;
  logic sw_copy;
  logic sw_start;
  logic sw_scroll;
  logic sw_go;
  logic pend_valid;
  logic [tccs_pkg::ADDR_W-1:0] pend_addr;
  logic pend_copy;

  // Output register.
  logic        res_valid;
  logic        res_load;
  logic [6:0]  res_col;
  logic [4:0]  res_row;
  logic [10:0] res_lin;
  logic [15:0] res_cell;

  // Helpers for the execute step.
  logic [15:0] blank_cell;
  logic        back_ok;
  logic [tccs_pkg::COL_W-1:0] back_col;
  logic [tccs_pkg::ROW_W-1:0] back_row;
  logic        pos_ok;
  logic [tccs_pkg::COL_W-1:0] x_idx;
  logic [tccs_pkg::ROW_W-1:0] y_idx;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Handshake outputs.
  assign cmd_ch.ready         = (state == tccs_pkg::ST_IDLE);
  assign res_ch.valid         = res_valid;
  assign res_ch.cursor_col    = res_col;
  assign res_ch.cursor_row    = res_row;
  assign res_ch.cursor_linear = res_lin;
  assign res_ch.cell_value    = res_cell;

  // Step-back position, position checks, blank cell and sweep end.
  always_comb begin
    back_ok  = (cur_col != '0) || (cur_row != '0);
    back_col = (cur_col != '0) ? cur_col - 1'b1 : tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1);
    back_row = (cur_col != '0) ? cur_row : cur_row - 1'b1;
    pos_ok   = (x_q < 8'(tccs_pkg::COLUMNS)) && (y_q < 8'(tccs_pkg::ROWS));
    x_idx    = x_q[tccs_pkg::COL_W-1:0];
    y_idx    = y_q[tccs_pkg::ROW_W-1:0];
    blank_cell = (state == tccs_pkg::ST_INIT) ? tccs_pkg::RESET_CELL
                                              : {attr, tccs_pkg::CH_BLANK};
    sw_go    = (sw_ptr != tccs_pkg::ADDR_W'(tccs_pkg::CELL_COUNT));
  end

  // Next state, cursor and memory control.
  always_comb begin
    state_next = state;
    col_next   = cur_col;
    row_next   = cur_row;
    mem_we     = pend_valid;
    mem_waddr  = pend_addr;
    mem_wdata  = pend_copy ? mem_rdata : blank_cell;
    mem_re     = 1'b0;
    mem_raddr  = sw_ptr + tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS);
    sw_start   = 1'b0;
    sw_scroll  = 1'b0;
    res_load   = 1'b0;

    unique case (state)
      tccs_pkg::ST_INIT, tccs_pkg::ST_SWEEP: begin
        if (sw_go) begin
          mem_re = sw_copy && (sw_ptr < tccs_pkg::ADDR_W'(tccs_pkg::COPY_END));
        end else begin
          state_next = (state == tccs_pkg::ST_INIT) ? tccs_pkg::ST_IDLE
                                                    : tccs_pkg::ST_DONE;
        end
      end

      tccs_pkg::ST_IDLE: begin
        if (cmd_ch.valid) begin
          state_next = tccs_pkg::ST_EXEC;
        end
      end

      tccs_pkg::ST_EXEC: begin
        state_next = tccs_pkg::ST_DONE;
        case (cmd_q)
          tccs_pkg::CMD_PUT_CHAR: begin
            if (char_q == tccs_pkg::CH_NEWLINE) begin
              col_next = '0;
              if (cur_row == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1)) begin
                sw_start = 1'b1;
                sw_scroll = 1'b1;
              end else begin
                row_next = cur_row + 1'b1;
              end
            end else if (char_q == tccs_pkg::CH_RETURN) begin
              col_next = '0;
            end else if (char_q == tccs_pkg::CH_BACKSPACE) begin
              if (back_ok) begin
                col_next = back_col;
                row_next = back_row;
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tccs_pkg::cell_addr(cur_row, cur_col);
              mem_wdata = {attr, char_q};
              if (cur_col == tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1)) begin
                col_next = '0;
                if (cur_row == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1)) begin
                  sw_start = 1'b1;
                  sw_scroll = 1'b1;
                end else begin
                  row_next = cur_row + 1'b1;
                end
              end else begin
                col_next = cur_col + 1'b1;
              end
            end
          end
          tccs_pkg::CMD_ERASE_BACK: begin
            if (back_ok) begin
              col_next  = back_col;
              row_next  = back_row;
              mem_we    = 1'b1;
              mem_waddr = tccs_pkg::cell_addr(back_row, back_col);
              mem_wdata = {attr, tccs_pkg::CH_BLANK};
            end
          end
          tccs_pkg::CMD_PUT_AT: begin
            if (pos_ok) begin
              mem_we    = 1'b1;
              mem_waddr = tccs_pkg::cell_addr(y_idx, x_idx);
              mem_wdata = {attr, char_q};
            end
          end
          tccs_pkg::CMD_SET_CURSOR: begin
            col_next = (x_q >= 8'(tccs_pkg::COLUMNS))
                     ? tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1) : x_idx;
            row_next = (y_q >= 8'(tccs_pkg::ROWS))
                     ? tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1) : y_idx;
          end
          tccs_pkg::CMD_CLEAR: begin
            col_next = '0;
            row_next = '0;
            sw_start = 1'b1;
          end
          tccs_pkg::CMD_READ_CELL: begin
            if (pos_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = tccs_pkg::cell_addr(y_idx, x_idx);
              state_next = tccs_pkg::ST_READ_WAIT;
            end
          end
          default: begin
          end
        endcase
        if (sw_start) begin
          state_next = tccs_pkg::ST_SWEEP;
        end
      end

      tccs_pkg::ST_READ_WAIT: begin
        state_next = tccs_pkg::ST_DONE;
      end

      tccs_pkg::ST_DONE: begin
        if (!res_valid || res_ch.ready) begin
          res_load   = 1'b1;
          state_next = tccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tccs_pkg::ST_INIT;
      end
    endcase
  end

  // State, cursor, attribute and sweep control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tccs_pkg::ST_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      attr       <= tccs_pkg::RESET_ATTR;
      sw_ptr     <= '0;
      sw_copy    <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      cur_col <= col_next;
      cur_row <= row_next;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end

      // Sweep pointer and the write that follows each sweep step in the next cycle.
      pend_valid <= 1'b0;
      if (sw_start) begin
        sw_ptr  <= '0;
        sw_copy <= sw_scroll;
      end else if ((state == tccs_pkg::ST_INIT || state == tccs_pkg::ST_SWEEP) && sw_go) begin
        sw_ptr     <= sw_ptr + 1'b1;
        pend_valid <= 1'b1;
      end

      // Result register is free once its transfer completes.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_addr <= sw_ptr;
    pend_copy <= mem_re && (state == tccs_pkg::ST_INIT || state == tccs_pkg::ST_SWEEP);
    if (cmd_ch.valid && cmd_ch.ready) begin
      cmd_q  <= tccs_pkg::cmd_t'(cmd_ch.cmd);
      char_q <= cmd_ch.char_code;
      x_q    <= cmd_ch.col_in;
      y_q    <= cmd_ch.row_in;
    end
    if (state == tccs_pkg::ST_EXEC) begin
      cell_q <= '0;
    end else if (state == tccs_pkg::ST_READ_WAIT) begin
      cell_q <= mem_rdata;
    end
    if (res_load) begin
      res_col  <= 7'(cur_col);
      res_row  <= 5'(cur_row);
      res_lin  <= 11'(tccs_pkg::cell_addr(cur_row, cur_col));
      res_cell <= cell_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/tccs_checker.sv =====
// Port-level checks for the text console core and their bind.
`default_nettype none

`include "text_console_cursor_scroll_core_assert.svh"

module tccs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic [6:0]  cursor_col,
  input wire logic [4:0]  cursor_row,
  input wire logic [10:0] cursor_linear
);

  // A shown cursor always lies on the screen.
  `TCCS_ASSERT_SAME(a_col_range, clk, rst, out_valid, cursor_col < 7'(tccs_pkg::COLUMNS))
  `TCCS_ASSERT_SAME(a_row_range, clk, rst, out_valid, cursor_row < 5'(tccs_pkg::ROWS))

  // The linear position agrees with the row and column it is shown with.
  `TCCS_ASSERT_SAME(a_linear, clk, rst, out_valid,
    cursor_linear == 11'(tccs_pkg::cell_addr(cursor_row, cursor_col)))

  // Commands are handled one at a time: a transfer leaves the input busy.
  `TCCS_ASSERT_NEXT(a_busy_after_cmd, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd_ch.valid),
  .in_ready      (cmd_ch.ready),
  .out_valid     (res_ch.valid),
  .cursor_col    (res_ch.cursor_col),
  .cursor_row    (res_ch.cursor_row),
  .cursor_linear (res_ch.cursor_linear)
);

`default_nettype wire

// ===== tb/text_console_cursor_scroll_core_test.sv =====
// Self-checking testbench for the text console core: directed cases, then random command traffic.
module text_console_cursor_scroll_core_test;

  // Spare command codes that the core treats as no operation.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int CLK_PERIOD   = 8;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SWEEP_BUDGET = 70;
  localparam int PHASE_ITEMS  = 480;

  // One expected result transfer.
  typedef struct {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] linear;
    logic [15:0] cell_val;
  } cursor_report_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  tccs_cmd_if cmd_ch ();
  tccs_res_if res_ch ();

  text_console_cursor_scroll_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_ch   (cmd_ch),
    .res_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Mirror of the console state.
  logic [15:0]    screen_model [tccs_pkg::CELL_COUNT];
  int             cur_col;
  int             cur_row;
  logic [7:0]     text_attr_model;
  int             sweeps_done;
  int             sweep_cap;

  cursor_report_t pending_reports [$];
  int             fail_count;
  int             cycle_count;
  bit             no_idle;
  bit             hold_req;
  bit             cmd_offered;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Idle gap: mostly short, now and then long, none during quiet stretches.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 80);
  endfunction

  // Coordinate mostly on screen, sometimes anywhere in the byte range.
  function automatic logic [7:0] pick_coord(input int span);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [15:0] blank_cell();
    return {text_attr_model, tccs_pkg::CH_BLANK};
  endfunction

  function automatic void model_scroll();
    for (int i = 0; i < tccs_pkg::COPY_END; i++) begin
      screen_model[i] = screen_model[i + tccs_pkg::COLUMNS];
    end
    for (int i = 0; i < tccs_pkg::COLUMNS; i++) begin
      screen_model[tccs_pkg::COPY_END + i] = blank_cell();
    end
    sweeps_done++;
  endfunction

  function automatic void model_next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= tccs_pkg::ROWS) begin
      model_scroll();
      cur_row = tccs_pkg::ROWS - 1;
    end
  endfunction

  // Move the cursor back one cell; false at the top-left corner.
  function automatic bit model_step_back();
    if (cur_col > 0) begin
      cur_col--;
    end else if (cur_row > 0) begin
      cur_row--;
      cur_col = tccs_pkg::COLUMNS - 1;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void model_put_char(input logic [7:0] ch);
    if (ch == tccs_pkg::CH_NEWLINE) begin
      model_next_line();
    end else if (ch == tccs_pkg::CH_RETURN) begin
      cur_col = 0;
    end else if (ch == tccs_pkg::CH_BACKSPACE) begin
      void'(model_step_back());
    end else begin
      screen_model[cur_row * tccs_pkg::COLUMNS + cur_col] = {text_attr_model, ch};
      cur_col++;
      if (cur_col >= tccs_pkg::COLUMNS) model_next_line();
    end
  endfunction

  // True when the command would make the core sweep the whole screen.
  function automatic bit model_would_sweep(input logic [2:0] code, input logic [7:0] ch);
    if (code == tccs_pkg::CMD_CLEAR) return 1'b1;
    if (code != tccs_pkg::CMD_PUT_CHAR || cur_row != tccs_pkg::ROWS - 1) return 1'b0;
    if (ch == tccs_pkg::CH_NEWLINE) return 1'b1;
    return ch != tccs_pkg::CH_RETURN && ch != tccs_pkg::CH_BACKSPACE &&
           cur_col == tccs_pkg::COLUMNS - 1;
  endfunction

  // Apply one accepted command to the mirror and queue the result it causes.
  function automatic void console_model_apply(input logic [2:0] code, input logic [7:0] ch,
                                              input logic [7:0] x, input logic [7:0] y);
    logic [15:0]    cell_data;
    cursor_report_t rep;
    cell_data = '0;
    case (code)
      tccs_pkg::CMD_PUT_CHAR: model_put_char(ch);
      tccs_pkg::CMD_ERASE_BACK: begin
        if (model_step_back()) begin
          screen_model[cur_row * tccs_pkg::COLUMNS + cur_col] = blank_cell();
        end
      end
      tccs_pkg::CMD_PUT_AT: begin
        if (x < tccs_pkg::COLUMNS && y < tccs_pkg::ROWS) begin
          screen_model[y * tccs_pkg::COLUMNS + x] = {text_attr_model, ch};
        end
      end
      tccs_pkg::CMD_SET_CURSOR: begin
        cur_col = (x >= tccs_pkg::COLUMNS) ? tccs_pkg::COLUMNS - 1 : int'(x);
        cur_row = (y >= tccs_pkg::ROWS) ? tccs_pkg::ROWS - 1 : int'(y);
      end
      tccs_pkg::CMD_CLEAR: begin
        for (int i = 0; i < tccs_pkg::CELL_COUNT; i++) screen_model[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        sweeps_done++;
      end
      tccs_pkg::CMD_READ_CELL: begin
        if (x < tccs_pkg::COLUMNS && y < tccs_pkg::ROWS) begin
          cell_data = screen_model[y * tccs_pkg::COLUMNS + x];
        end
      end
      default: ;
    endcase
    rep.col      = 7'(cur_col);
    rep.row      = 5'(cur_row);
    rep.linear   = 11'(cur_row * tccs_pkg::COLUMNS + cur_col);
    rep.cell_val = cell_data;
    pending_reports.push_back(rep);
  endfunction

  // Offer one command and wait for its transfer; valid stays high for a back-to-back item.
  task automatic send_cmd(input logic [2:0] code, input logic [7:0] ch,
                          input logic [7:0] x, input logic [7:0] y);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      if (cmd_offered) cmd_ch.valid <= 1'b0;
      cmd_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= code;
    cmd_ch.char_code <= ch;
    cmd_ch.col_in    <= x;
    cmd_ch.row_in    <= y;
    cmd_offered = 1'b1;
    do @(posedge clk); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
    console_model_apply(code, ch, x, y);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic wait_for_reports();
    if (cmd_offered) cmd_ch.valid <= 1'b0;
    cmd_offered = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_attr_model = value;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0 && !no_idle) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    cursor_report_t exp_rep;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (res_ch.cursor_col !== exp_rep.col) begin
          $error("cursor_col: expected %0d, actual %0d", exp_rep.col, res_ch.cursor_col);
          fail_count++;
        end
        if (res_ch.cursor_row !== exp_rep.row) begin
          $error("cursor_row: expected %0d, actual %0d", exp_rep.row, res_ch.cursor_row);
          fail_count++;
        end
        if (res_ch.cursor_linear !== exp_rep.linear) begin
          $error("cursor_linear: expected %0d, actual %0d", exp_rep.linear,
                 res_ch.cursor_linear);
          fail_count++;
        end
        if (res_ch.cell_value !== exp_rep.cell_val) begin
          $error("cell_value: expected 0x%04h, actual 0x%04h", exp_rep.cell_val,
                 res_ch.cell_value);
          fail_count++;
        end
      end
    end
  end

  // Screen after reset, including reads off the edge of the screen.
  task automatic test_reset_contents();
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'd0, 8'd0);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS - 1),
             8'(tccs_pkg::ROWS - 1));
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS), 8'd0);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'd0, 8'(tccs_pkg::ROWS));
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'hFF, 8'hFF);
  endtask

  // Printing at the right edge wraps; bytes from 0x80 up stay unsigned.
  task automatic test_print_and_wrap();
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'(tccs_pkg::COLUMNS - 2), 8'd0);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h41, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'hFF, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h80, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS - 1), 8'd0);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'd0, 8'd1);
  endtask

  // Newline, return and backspace only move the cursor.
  task automatic test_control_chars();
    send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_NEWLINE, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_RETURN, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'd0, 8'd0);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_BACKSPACE, 8'h00, 8'h00);
  endtask

  // Erase back at the top-left and across a line start.
  task automatic test_erase_back();
    send_cmd(tccs_pkg::CMD_ERASE_BACK, 8'h00, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'd0, 8'd2);
    send_cmd(tccs_pkg::CMD_ERASE_BACK, 8'h00, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS - 1), 8'd1);
  endtask

  // Put at: the bottom-right corner is written, positions off the screen are ignored.
  task automatic test_put_at_bounds();
    send_cmd(tccs_pkg::CMD_PUT_AT, 8'h7E, 8'(tccs_pkg::COLUMNS - 1), 8'(tccs_pkg::ROWS - 1));
    send_cmd(tccs_pkg::CMD_PUT_AT, 8'h55, 8'(tccs_pkg::COLUMNS), 8'(tccs_pkg::ROWS - 1));
    send_cmd(tccs_pkg::CMD_PUT_AT, 8'hAA, 8'd0, 8'(tccs_pkg::ROWS));
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS - 1),
             8'(tccs_pkg::ROWS - 1));
  endtask

  // Set cursor clamps each coordinate to the last column and row.
  task automatic test_cursor_clamp();
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'hFF, 8'hFF);
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'd5, 8'(tccs_pkg::ROWS));
  endtask

  // Scrolling by wrapping off the last line and by newline on it.
  task automatic test_scroll();
    send_cmd(tccs_pkg::CMD_SET_CURSOR, 8'h00, 8'(tccs_pkg::COLUMNS - 1),
             8'(tccs_pkg::ROWS - 1));
    send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h5A, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, tccs_pkg::CH_NEWLINE, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'(tccs_pkg::COLUMNS - 1),
             8'(tccs_pkg::ROWS - 3));
  endtask

  // Clear fills the screen with blanks in the current attribute.
  task automatic test_clear();
    wait_for_reports();
    write_attribute(8'hA5);
    send_cmd(tccs_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00);
    send_cmd(tccs_pkg::CMD_READ_CELL, 8'h00, 8'd3, 8'd7);
    send_cmd(tccs_pkg::CMD_PUT_CHAR, 8'h7F, 8'h00, 8'h00);
  endtask

  task automatic test_spare_codes();
    send_cmd(CMD_SPARE_6, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(CMD_SPARE_7, 8'h00, 8'd0, 8'd0);
  endtask

  // Receiver holds off while commands keep coming, so the core backs up.
  task automatic test_back_pressure();
    wait_for_reports();
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_cmd(($urandom_range(0, 1) == 0) ? tccs_pkg::CMD_PUT_CHAR : tccs_pkg::CMD_READ_CELL,
               8'($urandom_range(32, 126)), pick_coord(tccs_pkg::COLUMNS),
               pick_coord(tccs_pkg::ROWS));
    end
    wait_for_reports();
  endtask

  // Random commands, mostly ordinary text, with the number of screen sweeps kept in check.
  task automatic test_random_traffic(input int count);
    logic [2:0]  code;
    logic [7:0]  ch;
    logic [7:0]  x;
    logic [7:0]  y;
    int unsigned r;
    sweep_cap = sweeps_done + SWEEP_BUDGET;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 4) == 0);
      r    = $urandom_range(0, 199);
      ch   = 8'($urandom_range(0, 255));
      x    = pick_coord(tccs_pkg::COLUMNS);
      y    = pick_coord(tccs_pkg::ROWS);
      code = tccs_pkg::CMD_PUT_CHAR;
      if (r < 110) code = tccs_pkg::CMD_PUT_CHAR;
      else if (r < 120) ch = tccs_pkg::CH_NEWLINE;
      else if (r < 126) ch = tccs_pkg::CH_RETURN;
      else if (r < 132) ch = tccs_pkg::CH_BACKSPACE;
      else if (r < 146) code = tccs_pkg::CMD_ERASE_BACK;
      else if (r < 160) code = tccs_pkg::CMD_PUT_AT;
      else if (r < 172) code = tccs_pkg::CMD_SET_CURSOR;
      else if (r < 190) code = tccs_pkg::CMD_READ_CELL;
      else if (r < 193) code = tccs_pkg::CMD_CLEAR;
      else if (r < 196) code = CMD_SPARE_6;
      else code = CMD_SPARE_7;
      if (sweeps_done >= sweep_cap && model_would_sweep(code, ch)) begin
        code = tccs_pkg::CMD_SET_CURSOR;
      end
      send_cmd(code, ch, x, y);
    end
    no_idle = 1'b0;
  endtask

  // Random phase under a fresh attribute.
  task automatic test_attribute_phase(input logic [7:0] value);
    wait_for_reports();
    write_attribute(value);
    test_random_traffic(PHASE_ITEMS);
  endtask

  // Main sequence.
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 8'h00;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.cmd       <= tccs_pkg::CMD_PUT_CHAR;
    cmd_ch.char_code <= 8'h00;
    cmd_ch.col_in    <= 8'h00;
    cmd_ch.row_in    <= 8'h00;
    fail_count      = 0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    cmd_offered     = 1'b0;
    sweeps_done     = 0;
    sweep_cap       = 0;
    cur_col         = 0;
    cur_row         = 0;
    text_attr_model = tccs_pkg::RESET_ATTR;
    for (int i = 0; i < tccs_pkg::CELL_COUNT; i++) screen_model[i] = tccs_pkg::RESET_CELL;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_print_and_wrap();
    test_control_chars();
    test_erase_back();
    test_put_at_bounds();
    test_cursor_clamp();
    test_scroll();
    test_clear();
    test_spare_codes();
    test_back_pressure();
    test_attribute_phase(8'hFF);
    test_attribute_phase(8'h00);
    test_attribute_phase(8'($urandom_range(1, 254)));
    test_attribute_phase(8'($urandom_range(0, 255)));

    // Let the last results arrive, then watch for any stray result before the verdict.
    wait_for_reports();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tccs_pkg.sv
design/tccs_if.sv
design/text_console_cursor_scroll_core.sv
design/tccs_checker.sv
tb/text_console_cursor_scroll_core_test.sv
